// ===== rtl/mngr_pkg.sv =====
// Package for the mutualistic network growth-rate block.
// Holds payload structs, register indexes, sequencer states and widths.
// No dependencies.
`timescale 1ns / 1ps

package mngr_pkg;

   localparam int DATA_W    = 32;
   localparam int IDX_W     = 6;
   localparam int CNT_W     = 7;
   localparam int CSR_IDX_W = 3;
   localparam int WIDE_W    = 80;

   localparam int DEF_MAX_NODES = 64;
   localparam int DEF_MAX_EDGES = 256;
   localparam int DEF_FRAC_BITS = 16;

   typedef enum logic [1:0] {
      MODE_WRITE_NODE  = 2'd0,
      MODE_APPEND_EDGE = 2'd1,
      MODE_EVALUATE    = 2'd2,
      MODE_CLEAR_EDGES = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GROWTH_ALPHA   = 3'd0,
      REG_INTRA_COMP     = 3'd1,
      REG_INTER_COMP     = 3'd2,
      REG_HANDLING_TIME  = 3'd3,
      REG_POLLINATOR_CNT = 3'd4,
      REG_PLANT_CNT      = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [1:0]               mode;
      logic [IDX_W-1:0]         node_index;
      logic signed [DATA_W-1:0] abundance;
      logic signed [DATA_W-1:0] benefit_rate;
      logic [IDX_W-1:0]         edge_first;
      logic [IDX_W-1:0]         edge_second;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0]         result_node;
      logic signed [DATA_W-1:0] growth_rate;
      logic                     saturated;
      logic                     last;
   } rsp_payload_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_Q_START,
      ST_Q_WAIT,
      ST_CLEAR,
      ST_CLEAR_END,
      ST_E_ADDR,
      ST_E_READ,
      ST_E_FIRST,
      ST_E_SECOND_RD,
      ST_E_SECOND_WR,
      ST_N_READ,
      ST_N_LOAD,
      ST_M_GN,
      ST_M_HGN,
      ST_DEN,
      ST_DIV_START,
      ST_INTRA,
      ST_INTER,
      ST_DIV_WAIT,
      ST_SUM,
      ST_M_FINAL,
      ST_OUT
   } state_type;

endpackage

// ===== rtl/mngr_div.sv =====
// Shared signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on mngr_pkg. Divisor must be non-zero.
`timescale 1ns / 1ps

module mngr_div #(
   parameter int DIVIDEND_W = mngr_pkg::DATA_W + mngr_pkg::DEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [DIVIDEND_W-1:0]        dividend,
   input  logic signed [mngr_pkg::DATA_W-1:0]  divisor,
   output mngr_pkg::div_status_type            status,
   output logic signed [DIVIDEND_W:0]          quotient
);

   localparam int DW      = mngr_pkg::DATA_W;
   localparam int STEP_W  = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DW-1:0]         rem_ff, rem_in;
   logic [DW-1:0]         dsr_ff, dsr_in;
   logic                  neg_ff, neg_in;
   logic [DW:0]           trial;
   logic                  fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      fits    = trial >= {1'b0, dsr_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_W'(DIVIDEND_W);
         dvd_in  = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
         dsr_in  = divisor[DW-1] ? DW'(-divisor) : DW'(divisor);
         rem_in  = '0;
         neg_in  = dividend[DIVIDEND_W-1] ^ divisor[DW-1];
      end else if (busy_ff) begin
         rem_in = fits ? DW'(trial - {1'b0, dsr_ff}) : trial[DW-1:0];
         dvd_in = {dvd_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, dvd_ff}) : $signed({1'b0, dvd_ff});

endmodule

// ===== rtl/mutualistic_network_growth_rate.sv =====
// Top level: growth rates of a bipartite mutualistic network, Q16.16 fixed point.
// Depends on mngr_pkg and mngr_div.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  mngr_pkg::req_payload_type
//   rsp_      out        rsp_valid/rsp_stall  mngr_pkg::rsp_payload_type
//   csr_      in         csr_wr_en            csr_index, csr_wdata
//
// Load, append and clear transactions are handled in the idle state without leaving it.
// An evaluation runs the bit-serial divider and walks the node and edge memories.
// req_stall is high for the whole evaluation; a result waits in the output register.
// Reset is synchronous; node and edge memories hold nothing defined until written.
`timescale 1ns / 1ps

module mutualistic_network_growth_rate #(
   parameter int MAX_NODES = mngr_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = mngr_pkg::DEF_MAX_EDGES,
   parameter int FRAC_BITS = mngr_pkg::DEF_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  mngr_pkg::req_payload_type             req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output mngr_pkg::rsp_payload_type             rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [mngr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mngr_pkg::DATA_W-1:0]           csr_wdata
);

   localparam int DW      = mngr_pkg::DATA_W;
   localparam int CW      = mngr_pkg::CNT_W;
   localparam int XW      = mngr_pkg::WIDE_W;
   localparam int NODE_AW = $clog2(MAX_NODES);
   localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
   localparam int NSUM_W  = DW + ECNT_W + 1;
   localparam int GS_W    = DW + NODE_AW;
   localparam int DIV_W   = DW + FRAC_BITS;
   localparam int MUL_W   = DW + 1;
   localparam int PROD_W  = 2 * MUL_W;
   localparam logic signed [DW+1:0] ONE_W = (DW+2)'(1) <<< FRAC_BITS;
   localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};

   // {flag, value}: clamp a wide signed value to 32 bits
   function automatic logic [DW:0] sat32(input logic signed [XW-1:0] v);
      logic [DW:0] r;
      if (v > XW'(S_MAX))      r = {1'b1, S_MAX};
      else if (v < XW'(S_MIN)) r = {1'b1, S_MIN};
      else                     r = {1'b0, v[DW-1:0]};
      return r;
   endfunction

   // memories
   logic signed [DW-1:0]     ab_mem [MAX_NODES];
   logic signed [DW-1:0]     bn_mem [MAX_NODES];
   logic [NODE_AW-1:0]       ef_mem [MAX_EDGES];
   logic [NODE_AW-1:0]       es_mem [MAX_EDGES];
   logic signed [NSUM_W-1:0] ns_mem [MAX_NODES];

   logic                     node_we, edge_we, ns_we;
   logic [NODE_AW-1:0]       node_waddr, ab_raddr_a, ab_raddr_b, bn_raddr;
   logic [NODE_AW-1:0]       ns_waddr, ns_raddr;
   logic [EDGE_AW-1:0]       edge_waddr, edge_raddr;
   logic signed [NSUM_W-1:0] ns_wdata;
   logic signed [DW-1:0]     ab_rd_a_ff, ab_rd_b_ff, bn_rd_ff;
   logic [NODE_AW-1:0]       ef_rd_ff, es_rd_ff;
   logic signed [NSUM_W-1:0] ns_rd_ff;

   always_ff @(posedge clock) begin
      if (node_we) begin
         ab_mem[node_waddr] <= req_data.abundance;
         bn_mem[node_waddr] <= req_data.benefit_rate;
      end
      ab_rd_a_ff <= ab_mem[ab_raddr_a];
      ab_rd_b_ff <= ab_mem[ab_raddr_b];
      bn_rd_ff   <= bn_mem[bn_raddr];
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         ef_mem[edge_waddr] <= NODE_AW'(req_data.edge_first);
         es_mem[edge_waddr] <= NODE_AW'(req_data.edge_second);
      end
      ef_rd_ff <= ef_mem[edge_raddr];
      es_rd_ff <= es_mem[edge_raddr];
   end

   always_ff @(posedge clock) begin
      if (ns_we) begin
         ns_mem[ns_waddr] <= ns_wdata;
      end
      ns_rd_ff <= ns_mem[ns_raddr];
   end

   // registers
   mngr_pkg::state_type       state_ff, state_in;
   logic signed [DW-1:0]      alpha_ff, alpha_in, bii_ff, bii_in, bij_ff, bij_in;
   logic [DW-2:0]             h_ff, h_in;
   logic [5:0]                pc_ff, pc_in, pl_ff, pl_in;
   logic [ECNT_W-1:0]         edge_cnt_ff, edge_cnt_in, e_ff, e_in;
   logic [CW-1:0]             nb_ff, nb_in, total_ff, total_in, node_ff, node_in;
   logic                      qsel_ff, qsel_in;
   logic signed [DW-1:0]      q_pol_ff, q_pol_in, q_pla_ff, q_pla_in;
   logic [NODE_AW-1:0]        sweep_ff, sweep_in, acc_idx_ff, acc_idx_in;
   logic                      acc_v_ff, acc_v_in;
   logic signed [GS_W-1:0]    sum_pol_ff, sum_pol_in, sum_pla_ff, sum_pla_in;
   logic [NODE_AW-1:0]        ea_ff, ea_in, eb_ff, eb_in;
   logic signed [DW-1:0]      ya_ff, ya_in;
   logic signed [DW-1:0]      y_ff, y_in, g_ff, g_in, n_ff, n_in, diff_ff, diff_in;
   logic signed [DW-1:0]      gn_ff, gn_in, den_ff, den_in, intra_ff, intra_in;
   logic signed [DW-1:0]      inter_ff, inter_in, mut_ff, mut_in, sum_ff, sum_in;
   logic                      den_zero_ff, den_zero_in, flag_ff, flag_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   mngr_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic                      mul_en;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [PROD_W-1:0]  prod_sh;
   logic [DW:0]               fx, st;
   logic [CW-1:0]             cnt_pol, room, cnt_pla, gcnt;
   logic                      is_pol, is_last;
   logic                      div_start;
   logic signed [DIV_W-1:0]   div_dividend;
   logic signed [DW-1:0]      div_divisor;
   mngr_pkg::div_status_type  div_stat;
   logic signed [DIV_W:0]     div_quot;
   logic signed [DW+1:0]      den_wide;
   logic signed [DW+2:0]      acc_wide;

   mngr_div #(
      .DIVIDEND_W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_stat),
      .quotient (div_quot)
   );

   assign prod_sh = prod_ff >>> FRAC_BITS;
   assign fx      = sat32(XW'(prod_sh));
   assign is_pol  = node_ff < nb_ff;
   assign is_last = (node_ff + 1'b1) == total_ff;

   always_comb begin
      cnt_pol = ({1'b0, pc_ff} > CW'(MAX_NODES)) ? CW'(MAX_NODES) : {1'b0, pc_ff};
      room    = CW'(MAX_NODES) - cnt_pol;
      cnt_pla = ({1'b0, pl_ff} > room) ? room : {1'b0, pl_ff};
      gcnt    = qsel_ff ? (total_ff - nb_ff) : nb_ff;
   end

   always_comb begin
      state_in     = state_ff;
      alpha_in     = alpha_ff;
      bii_in       = bii_ff;
      bij_in       = bij_ff;
      h_in         = h_ff;
      pc_in        = pc_ff;
      pl_in        = pl_ff;
      edge_cnt_in  = edge_cnt_ff;
      e_in         = e_ff;
      nb_in        = nb_ff;
      total_in     = total_ff;
      node_in      = node_ff;
      qsel_in      = qsel_ff;
      q_pol_in     = q_pol_ff;
      q_pla_in     = q_pla_ff;
      sweep_in     = sweep_ff;
      acc_idx_in   = acc_idx_ff;
      acc_v_in     = 1'b0;
      sum_pol_in   = sum_pol_ff;
      sum_pla_in   = sum_pla_ff;
      ea_in        = ea_ff;
      eb_in        = eb_ff;
      ya_in        = ya_ff;
      y_in         = y_ff;
      g_in         = g_ff;
      n_in         = n_ff;
      diff_in      = diff_ff;
      gn_in        = gn_ff;
      den_in       = den_ff;
      intra_in     = intra_ff;
      inter_in     = inter_ff;
      mut_in       = mut_ff;
      sum_in       = sum_ff;
      den_zero_in  = den_zero_ff;
      flag_in      = flag_ff;
      prod_in      = prod_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      node_we      = 1'b0;
      node_waddr   = NODE_AW'(req_data.node_index);
      edge_we      = 1'b0;
      edge_waddr   = edge_cnt_ff[EDGE_AW-1:0];
      edge_raddr   = e_ff[EDGE_AW-1:0];
      ns_we        = 1'b0;
      ns_waddr     = sweep_ff;
      ns_wdata     = '0;
      ns_raddr     = node_ff[NODE_AW-1:0];
      ab_raddr_a   = node_ff[NODE_AW-1:0];
      ab_raddr_b   = eb_ff;
      bn_raddr     = node_ff[NODE_AW-1:0];

      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_dividend = DIV_W'(bij_ff);
      div_divisor  = DW'(gcnt >= CW'(2) ? gcnt - 1'b1 : CW'(1));
      st           = '0;
      den_wide     = '0;
      acc_wide     = '0;

      if (csr_wr_en) begin
         case (csr_index)
            mngr_pkg::REG_GROWTH_ALPHA:   alpha_in = csr_wdata;
            mngr_pkg::REG_INTRA_COMP:     bii_in   = csr_wdata;
            mngr_pkg::REG_INTER_COMP:     bij_in   = csr_wdata;
            mngr_pkg::REG_HANDLING_TIME:  h_in     = csr_wdata[DW-2:0];
            mngr_pkg::REG_POLLINATOR_CNT: pc_in    = csr_wdata[5:0];
            mngr_pkg::REG_PLANT_CNT:      pl_in    = csr_wdata[5:0];
            default: ;
         endcase
      end

      case (state_ff)
         mngr_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (mngr_pkg::mode_type'(req_data.mode))
                  mngr_pkg::MODE_WRITE_NODE: begin
                     node_we = {1'b0, req_data.node_index} < CW'(MAX_NODES);
                  end
                  mngr_pkg::MODE_APPEND_EDGE: begin
                     if ({1'b0, req_data.edge_first} < CW'(MAX_NODES) &&
                         {1'b0, req_data.edge_second} < CW'(MAX_NODES) &&
                         edge_cnt_ff < ECNT_W'(MAX_EDGES)) begin
                        edge_we     = 1'b1;
                        edge_cnt_in = edge_cnt_ff + 1'b1;
                     end
                  end
                  mngr_pkg::MODE_CLEAR_EDGES: begin
                     edge_cnt_in = '0;
                  end
                  mngr_pkg::MODE_EVALUATE: begin
                     nb_in      = cnt_pol;
                     total_in   = cnt_pol + cnt_pla;
                     qsel_in    = 1'b0;
                     sum_pol_in = '0;
                     sum_pla_in = '0;
                     if ((cnt_pol + cnt_pla) != '0) state_in = mngr_pkg::ST_Q_START;
                  end
                  default: ;
               endcase
            end
         end

         // per-guild quotient bij / (count - 1), divisor held at 1 for counts below 2
         mngr_pkg::ST_Q_START: begin
            div_start = 1'b1;
            state_in  = mngr_pkg::ST_Q_WAIT;
         end
         mngr_pkg::ST_Q_WAIT: begin
            if (div_stat.done) begin
               if (qsel_ff) begin
                  q_pla_in = div_quot[DW-1:0];
                  sweep_in = '0;
                  state_in = mngr_pkg::ST_CLEAR;
               end else begin
                  q_pol_in = div_quot[DW-1:0];
                  qsel_in  = 1'b1;
                  state_in = mngr_pkg::ST_Q_START;
               end
            end
         end

         // zero the neighbour sums and total each guild
         mngr_pkg::ST_CLEAR, mngr_pkg::ST_CLEAR_END: begin
            if (acc_v_ff) begin
               if (CW'(acc_idx_ff) < nb_ff)
                  sum_pol_in = sum_pol_ff + GS_W'(ab_rd_a_ff);
               else if (CW'(acc_idx_ff) < total_ff)
                  sum_pla_in = sum_pla_ff + GS_W'(ab_rd_a_ff);
            end
            if (state_ff == mngr_pkg::ST_CLEAR) begin
               ns_we      = 1'b1;
               ab_raddr_a = sweep_ff;
               acc_v_in   = 1'b1;
               acc_idx_in = sweep_ff;
               sweep_in   = sweep_ff + 1'b1;
               if (sweep_ff == NODE_AW'(MAX_NODES - 1)) state_in = mngr_pkg::ST_CLEAR_END;
            end else begin
               node_in = '0;
               e_in    = '0;
               state_in = (edge_cnt_ff != '0) ? mngr_pkg::ST_E_ADDR : mngr_pkg::ST_N_READ;
            end
         end

         // edge walk: read ends, then update each end's sum in turn
         mngr_pkg::ST_E_ADDR: begin
            state_in = mngr_pkg::ST_E_READ;
         end
         mngr_pkg::ST_E_READ: begin
            ab_raddr_a = ef_rd_ff;
            ab_raddr_b = es_rd_ff;
            ns_raddr   = ef_rd_ff;
            ea_in      = ef_rd_ff;
            eb_in      = es_rd_ff;
            state_in   = mngr_pkg::ST_E_FIRST;
         end
         mngr_pkg::ST_E_FIRST: begin
            ns_we    = 1'b1;
            ns_waddr = ea_ff;
            ns_wdata = ns_rd_ff + NSUM_W'(ab_rd_b_ff);
            ya_in    = ab_rd_a_ff;
            state_in = mngr_pkg::ST_E_SECOND_RD;
         end
         mngr_pkg::ST_E_SECOND_RD: begin
            ns_raddr = eb_ff;
            state_in = mngr_pkg::ST_E_SECOND_WR;
         end
         mngr_pkg::ST_E_SECOND_WR: begin
            ns_we    = 1'b1;
            ns_waddr = eb_ff;
            ns_wdata = ns_rd_ff + NSUM_W'(ya_ff);
            e_in     = e_ff + 1'b1;
            state_in = ((e_ff + 1'b1) == edge_cnt_ff) ? mngr_pkg::ST_N_READ
                                                       : mngr_pkg::ST_E_ADDR;
         end

         // per-node evaluation
         mngr_pkg::ST_N_READ: begin
            flag_in  = 1'b0;
            state_in = mngr_pkg::ST_N_LOAD;
         end
         mngr_pkg::ST_N_LOAD: begin
            y_in    = ab_rd_a_ff;
            g_in    = bn_rd_ff;
            st      = sat32(XW'(ns_rd_ff));
            n_in    = st[DW-1:0];
            flag_in = flag_ff | st[DW];
            if (is_pol) st = sat32(XW'(sum_pol_ff) - XW'(ab_rd_a_ff));
            else        st = sat32(XW'(sum_pla_ff) - XW'(ab_rd_a_ff));
            diff_in  = st[DW-1:0];
            flag_in  = flag_in | st[DW];
            state_in = mngr_pkg::ST_M_GN;
         end
         mngr_pkg::ST_M_GN: begin
            mul_en   = 1'b1;
            mul_a    = MUL_W'(g_ff);
            mul_b    = MUL_W'(n_ff);
            state_in = mngr_pkg::ST_M_HGN;
         end
         mngr_pkg::ST_M_HGN: begin
            gn_in    = fx[DW-1:0];
            flag_in  = flag_ff | fx[DW];
            mul_en   = 1'b1;
            mul_a    = $signed({2'b00, h_ff});
            mul_b    = MUL_W'($signed(fx[DW-1:0]));
            state_in = mngr_pkg::ST_DEN;
         end
         mngr_pkg::ST_DEN: begin
            den_wide    = ONE_W + (DW+2)'($signed(fx[DW-1:0]));
            st          = sat32(XW'(den_wide));
            den_in      = st[DW-1:0];
            den_zero_in = st[DW-1:0] == '0;
            flag_in     = flag_ff | fx[DW] | st[DW];
            state_in    = mngr_pkg::ST_DIV_START;
         end
         mngr_pkg::ST_DIV_START: begin
            div_dividend = {gn_ff, {FRAC_BITS{1'b0}}};
            div_divisor  = den_ff;
            div_start    = !den_zero_ff;
            mul_en       = 1'b1;
            mul_a        = MUL_W'(bii_ff);
            mul_b        = MUL_W'(y_ff);
            state_in     = mngr_pkg::ST_INTRA;
         end
         mngr_pkg::ST_INTRA: begin
            intra_in = fx[DW-1:0];
            flag_in  = flag_ff | fx[DW];
            mul_en   = 1'b1;
            mul_a    = MUL_W'(is_pol ? q_pol_ff : q_pla_ff);
            mul_b    = MUL_W'(diff_ff);
            state_in = mngr_pkg::ST_INTER;
         end
         mngr_pkg::ST_INTER: begin
            inter_in = fx[DW-1:0];
            flag_in  = flag_ff | fx[DW];
            state_in = mngr_pkg::ST_DIV_WAIT;
         end
         mngr_pkg::ST_DIV_WAIT: begin
            if (den_zero_ff) begin
               // zero denominator: clamp toward the sign of g*n
               flag_in  = 1'b1;
               mut_in   = (gn_ff > 0) ? S_MAX : ((gn_ff < 0) ? S_MIN : '0);
               state_in = mngr_pkg::ST_SUM;
            end else if (!div_stat.busy) begin
               st       = sat32(XW'(div_quot));
               mut_in   = st[DW-1:0];
               flag_in  = flag_ff | st[DW];
               state_in = mngr_pkg::ST_SUM;
            end
         end
         mngr_pkg::ST_SUM: begin
            acc_wide = (DW+3)'(alpha_ff) - (DW+3)'(intra_ff) - (DW+3)'(inter_ff)
                     + (DW+3)'(mut_ff);
            st       = sat32(XW'(acc_wide));
            sum_in   = st[DW-1:0];
            flag_in  = flag_ff | st[DW];
            state_in = mngr_pkg::ST_M_FINAL;
         end
         mngr_pkg::ST_M_FINAL: begin
            mul_en   = 1'b1;
            mul_a    = MUL_W'(sum_ff);
            mul_b    = MUL_W'(y_ff);
            state_in = mngr_pkg::ST_OUT;
         end
         mngr_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_node = mngr_pkg::IDX_W'(node_ff);
               rsp_data_in.growth_rate = fx[DW-1:0];
               rsp_data_in.saturated   = flag_ff | fx[DW];
               rsp_data_in.last        = is_last;
               node_in                 = node_ff + 1'b1;
               state_in = is_last ? mngr_pkg::ST_IDLE : mngr_pkg::ST_N_READ;
            end
         end
         default: state_in = mngr_pkg::ST_IDLE;
      endcase

      if (mul_en) prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mngr_pkg::ST_IDLE;
         alpha_ff     <= '0;
         bii_ff       <= '0;
         bij_ff       <= '0;
         h_ff         <= '0;
         pc_ff        <= 6'd2;
         pl_ff        <= 6'd2;
         edge_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         acc_v_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alpha_ff     <= alpha_in;
         bii_ff       <= bii_in;
         bij_ff       <= bij_in;
         h_ff         <= h_in;
         pc_ff        <= pc_in;
         pl_ff        <= pl_in;
         edge_cnt_ff  <= edge_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_v_ff     <= acc_v_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff        <= e_in;
      nb_ff       <= nb_in;
      total_ff    <= total_in;
      node_ff     <= node_in;
      qsel_ff     <= qsel_in;
      q_pol_ff    <= q_pol_in;
      q_pla_ff    <= q_pla_in;
      sweep_ff    <= sweep_in;
      acc_idx_ff  <= acc_idx_in;
      sum_pol_ff  <= sum_pol_in;
      sum_pla_ff  <= sum_pla_in;
      ea_ff       <= ea_in;
      eb_ff       <= eb_in;
      ya_ff       <= ya_in;
      y_ff        <= y_in;
      g_ff        <= g_in;
      n_ff        <= n_in;
      diff_ff     <= diff_in;
      gn_ff       <= gn_in;
      den_ff      <= den_in;
      intra_ff    <= intra_in;
      inter_ff    <= inter_in;
      mut_ff      <= mut_in;
      sum_ff      <= sum_in;
      den_zero_ff <= den_zero_in;
      flag_ff     <= flag_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = state_ff != mngr_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== test/mutualistic_network_growth_rate_test.sv =====
// Testbench for mutualistic_network_growth_rate: a directed table, then random phases,
// results checked against a fixed-point predictor of the network growth rates or typed values.
// Depends on mngr_pkg and the block's RTL.
`timescale 1ns / 1ps

module mutualistic_network_growth_rate_test;

   localparam longint SAT_HI    = 64'sd2147483647;
   localparam longint SAT_LO    = -64'sd2147483648;
   localparam longint ONE       = 64'sd65536;
   localparam int     NODES     = 64;
   localparam int     EDGES     = 256;
   localparam int     SETTLE    = 40;
   localparam longint CYCLE_CAP = 3000000;

   typedef struct {
      bit                          is_cfg;
      mngr_pkg::csr_index_type     reg_sel;
      logic [31:0]                 value;
      mngr_pkg::req_payload_type   item;
      bit                          typed;
      logic signed [31:0]          typed_rate;
      bit                          typed_sat;
   } step_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   mngr_pkg::req_payload_type req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   mngr_pkg::rsp_payload_type rsp_data;
   logic                      csr_wr_en;
   logic [2:0]                csr_index;
   logic [31:0]               csr_wdata;

   // predictor state
   logic signed [31:0] abund [NODES];
   logic signed [31:0] benefit [NODES];
   logic [5:0]         edge_a [EDGES];
   logic [5:0]         edge_b [EDGES];
   int                 edge_count;
   longint             alpha_r, intra_r, inter_r, htime_r;
   int                 poll_cnt, plant_cnt;

   mngr_pkg::rsp_payload_type rate_due[$];
   step_row_type              table_rows[$];
   int                        fail_count;
   int                        mismatch_count;
   bit                        quiet;
   int                        stall_left;
   longint                    cycles;

   mutualistic_network_growth_rate i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic longint clamp32(longint v, inout bit f);
      if (v > SAT_HI) begin
         f = 1'b1;
         return SAT_HI;
      end
      if (v < SAT_LO) begin
         f = 1'b1;
         return SAT_LO;
      end
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b, inout bit f);
      return clamp32((a * b) >>> 16, f);
   endfunction

   function automatic longint node_growth(int i, longint gsum, int cnt, longint nsum,
                                          inout bit f);
      longint y, g, n, gn, hgn, den, mut, intra, q, diff, inter, sum, divisor;
      y = abund[i];
      g = benefit[i];
      n = clamp32(nsum, f);
      gn = qmul(g, n, f);
      hgn = qmul(htime_r, gn, f);
      den = clamp32(ONE + hgn, f);
      if (den == 0) begin
         f = 1'b1;
         mut = gn > 0 ? SAT_HI : (gn < 0 ? SAT_LO : 0);
      end else begin
         mut = clamp32((gn * ONE) / den, f);
      end
      intra = qmul(intra_r, y, f);
      divisor = cnt >= 2 ? cnt - 1 : 1;
      q = inter_r / divisor;
      diff = clamp32(gsum - y, f);
      inter = qmul(q, diff, f);
      sum = clamp32(alpha_r - intra - inter + mut, f);
      return qmul(sum, y, f);
   endfunction

   // Apply one accepted transaction to the predictor and queue the growth rates it causes.
   task automatic apply_item(mngr_pkg::req_payload_type p);
      longint                    nsum [NODES];
      longint                    poll_sum, plant_sum, r;
      int                        nb, nf, total, a, b;
      bit                        f;
      mngr_pkg::rsp_payload_type want;
      case (mngr_pkg::mode_type'(p.mode))
         mngr_pkg::MODE_WRITE_NODE: begin
            abund[p.node_index] = p.abundance;
            benefit[p.node_index] = p.benefit_rate;
         end
         mngr_pkg::MODE_APPEND_EDGE: begin
            if (edge_count < EDGES) begin
               edge_a[edge_count] = p.edge_first;
               edge_b[edge_count] = p.edge_second;
               edge_count++;
            end
         end
         mngr_pkg::MODE_CLEAR_EDGES: edge_count = 0;
         default: begin
            nb = poll_cnt > NODES ? NODES : poll_cnt;
            nf = plant_cnt > NODES - nb ? NODES - nb : plant_cnt;
            total = nb + nf;
            poll_sum = 0;
            plant_sum = 0;
            for (int i = 0; i < total; i++) begin
               if (i < nb) poll_sum += abund[i];
               else plant_sum += abund[i];
            end
            foreach (nsum[i]) nsum[i] = 0;
            for (int k = 0; k < edge_count; k++) begin
               a = int'(edge_a[k]);
               b = int'(edge_b[k]);
               nsum[a] += abund[b];
               nsum[b] += abund[a];
            end
            for (int i = 0; i < total; i++) begin
               f = 1'b0;
               if (i < nb) r = node_growth(i, poll_sum, nb, nsum[i], f);
               else r = node_growth(i, plant_sum, nf, nsum[i], f);
               want.result_node = 6'(i);
               want.growth_rate = r[31:0];
               want.saturated = f;
               want.last = (i + 1 == total);
               rate_due.push_back(want);
            end
         end
      endcase
   endtask

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 15);
      case (r)
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h00000000;
         3: return 32'h00010000;
         4: return 32'hffff0000;
         default: begin
            if (r < 12) return $urandom_range(0, 32'h7ffff) - 32'h3ffff;
            return $urandom;
         end
      endcase
   endfunction

   task automatic send_item(mngr_pkg::req_payload_type p);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         if (req_valid) req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (req_stall);
      apply_item(p);
   endtask

   // Let the block finish every evaluation before touching its registers.
   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      while (rate_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(mngr_pkg::csr_index_type sel, logic [31:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (sel)
         mngr_pkg::REG_GROWTH_ALPHA:   alpha_r = longint'(signed'(v));
         mngr_pkg::REG_INTRA_COMP:     intra_r = longint'(signed'(v));
         mngr_pkg::REG_INTER_COMP:     inter_r = longint'(signed'(v));
         mngr_pkg::REG_HANDLING_TIME:  htime_r = longint'({1'b0, v[30:0]});
         mngr_pkg::REG_POLLINATOR_CNT: poll_cnt = int'(v[5:0]);
         mngr_pkg::REG_PLANT_CNT:      plant_cnt = int'(v[5:0]);
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic mngr_pkg::req_payload_type make_item(mngr_pkg::mode_type m, int idx,
                                                           logic [31:0] y, logic [31:0] g,
                                                           int a, int b);
      mngr_pkg::req_payload_type p;
      p.mode = m;
      p.node_index = 6'(idx);
      p.abundance = y;
      p.benefit_rate = g;
      p.edge_first = 6'(a);
      p.edge_second = 6'(b);
      return p;
   endfunction

   function automatic mngr_pkg::req_payload_type random_item(int weight_eval);
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return make_item(mngr_pkg::MODE_WRITE_NODE, $urandom_range(0, 63), pick_value(),
                          pick_value(), $urandom_range(0, 63), $urandom_range(0, 63));
      if (r < 90 - weight_eval)
         return make_item(mngr_pkg::MODE_APPEND_EDGE, $urandom_range(0, 63), $urandom,
                          $urandom, $urandom_range(0, 63), $urandom_range(0, 63));
      if (r < 97)
         return make_item(mngr_pkg::MODE_EVALUATE, $urandom_range(0, 63), $urandom,
                          $urandom, $urandom_range(0, 63), $urandom_range(0, 63));
      return make_item(mngr_pkg::MODE_CLEAR_EDGES, $urandom_range(0, 63), $urandom,
                       $urandom, $urandom_range(0, 63), $urandom_range(0, 63));
   endfunction

   function automatic void add_req(mngr_pkg::req_payload_type p);
      step_row_type s;
      s = '{reg_sel: mngr_pkg::REG_GROWTH_ALPHA, default: '0};
      s.item = p;
      table_rows.push_back(s);
   endfunction

   function automatic void add_cfg(mngr_pkg::csr_index_type sel, logic [31:0] v);
      step_row_type s;
      s = '{reg_sel: mngr_pkg::REG_GROWTH_ALPHA, default: '0};
      s.is_cfg = 1'b1;
      s.reg_sel = sel;
      s.value = v;
      table_rows.push_back(s);
   endfunction

   function automatic void build_table();
      step_row_type s;
      // all nodes hold zero and the registers their reset values: every rate is zero
      s = '{reg_sel: mngr_pkg::REG_GROWTH_ALPHA, default: '0};
      s.item = make_item(mngr_pkg::MODE_EVALUATE, 0, 0, 0, 0, 0);
      s.typed = 1'b1;
      table_rows.push_back(s);
      add_req(make_item(mngr_pkg::MODE_WRITE_NODE, 0, 32'h7fffffff, 32'h7fffffff, 0, 0));
      add_req(make_item(mngr_pkg::MODE_WRITE_NODE, 1, 32'h80000000, 32'h80000000, 0, 0));
      add_req(make_item(mngr_pkg::MODE_WRITE_NODE, 2, 32'hffff0000, 32'h00010000, 0, 0));
      add_req(make_item(mngr_pkg::MODE_WRITE_NODE, 3, 32'h00010000, 32'hffff0000, 0, 0));
      add_req(make_item(mngr_pkg::MODE_WRITE_NODE, 63, 32'h00008000, 32'h7fffffff, 0, 0));
      add_req(make_item(mngr_pkg::MODE_APPEND_EDGE, 0, 0, 0, 2, 3));
      add_req(make_item(mngr_pkg::MODE_APPEND_EDGE, 0, 0, 0, 0, 1));
      add_req(make_item(mngr_pkg::MODE_APPEND_EDGE, 0, 0, 0, 3, 3));
      add_req(make_item(mngr_pkg::MODE_APPEND_EDGE, 0, 0, 0, 63, 63));
      add_req(make_item(mngr_pkg::MODE_APPEND_EDGE, 0, 0, 0, 0, 63));
      add_req(make_item(mngr_pkg::MODE_EVALUATE, 0, 0, 0, 0, 0));
      // h = 1.0 with gn = -1.0 on node 3 gives a zero denominator
      add_cfg(mngr_pkg::REG_HANDLING_TIME, 32'h00010000);
      add_cfg(mngr_pkg::REG_GROWTH_ALPHA, 32'h00010000);
      add_cfg(mngr_pkg::REG_INTRA_COMP, 32'h7fffffff);
      add_cfg(mngr_pkg::REG_INTER_COMP, 32'h80000000);
      add_req(make_item(mngr_pkg::MODE_EVALUATE, 0, 0, 0, 0, 0));
      add_cfg(mngr_pkg::REG_POLLINATOR_CNT, 0);
      add_cfg(mngr_pkg::REG_PLANT_CNT, 1);
      add_req(make_item(mngr_pkg::MODE_EVALUATE, 0, 0, 0, 0, 0));
      // counts beyond the node limit are clipped
      add_cfg(mngr_pkg::REG_POLLINATOR_CNT, 63);
      add_cfg(mngr_pkg::REG_PLANT_CNT, 63);
      add_req(make_item(mngr_pkg::MODE_EVALUATE, 0, 0, 0, 0, 0));
      add_cfg(mngr_pkg::REG_POLLINATOR_CNT, 1);
      add_cfg(mngr_pkg::REG_PLANT_CNT, 0);
      add_req(make_item(mngr_pkg::MODE_EVALUATE, 0, 0, 0, 0, 0));
      add_cfg(mngr_pkg::REG_POLLINATOR_CNT, 0);
      add_req(make_item(mngr_pkg::MODE_EVALUATE, 0, 0, 0, 0, 0));
      add_cfg(mngr_pkg::REG_POLLINATOR_CNT, 3);
      add_cfg(mngr_pkg::REG_PLANT_CNT, 2);
      add_req(make_item(mngr_pkg::MODE_CLEAR_EDGES, 0, 0, 0, 0, 0));
      add_req(make_item(mngr_pkg::MODE_EVALUATE, 0, 0, 0, 0, 0));
   endfunction

   function automatic logic [31:0] count_word(int c);
      return ($urandom & 32'hffffffc0) | c;
   endfunction

   // response side: random stall and the comparison against the oldest expectation
   always @(posedge clock) begin
      mngr_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rate_due.size() == 0) begin
               fail_count++;
               if (mismatch_count < 10)
                  $display("unexpected transaction: node %0d rate %h", rsp_data.result_node,
                           rsp_data.growth_rate);
               mismatch_count++;
            end else begin
               want = rate_due.pop_front();
               if (rsp_data.result_node !== want.result_node
                   || rsp_data.growth_rate !== want.growth_rate
                   || rsp_data.saturated !== want.saturated
                   || rsp_data.last !== want.last) begin
                  fail_count++;
                  if (mismatch_count < 10)
                     $display({"mismatch: expected node %0d rate %h sat %b last %b,",
                               " got node %0d rate %h sat %b last %b"},
                              want.result_node, want.growth_rate, want.saturated, want.last,
                              rsp_data.result_node, rsp_data.growth_rate, rsp_data.saturated,
                              rsp_data.last);
                  mismatch_count++;
               end
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            rsp_stall <= stall_left > 0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int before_len;
      int items;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      rsp_stall = 1'b0;
      cycles = 0;
      fail_count = 0;
      mismatch_count = 0;
      quiet = 1'b0;
      edge_count = 0;
      alpha_r = 0;
      intra_r = 0;
      inter_r = 0;
      htime_r = 0;
      poll_cnt = 2;
      plant_cnt = 2;
      foreach (abund[i]) begin
         abund[i] = 0;
         benefit[i] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every node gets a defined value before anything is evaluated
      for (int i = 0; i < NODES; i++)
         send_item(make_item(mngr_pkg::MODE_WRITE_NODE, i, 0, 0, 0, 0));

      build_table();
      foreach (table_rows[k]) begin
         if (table_rows[k].is_cfg) begin
            drain();
            write_reg(table_rows[k].reg_sel, table_rows[k].value);
         end else begin
            before_len = rate_due.size();
            send_item(table_rows[k].item);
            if (table_rows[k].typed)
               for (int j = before_len; j < rate_due.size(); j++) begin
                  rate_due[j].growth_rate = table_rows[k].typed_rate;
                  rate_due[j].saturated = table_rows[k].typed_sat;
               end
         end
      end

      for (int phase = 0; phase < 10; phase++) begin
         drain();
         quiet = $urandom_range(0, 3) == 0;
         write_reg(mngr_pkg::REG_GROWTH_ALPHA, pick_value());
         write_reg(mngr_pkg::REG_INTRA_COMP, pick_value());
         write_reg(mngr_pkg::REG_INTER_COMP, pick_value());
         write_reg(mngr_pkg::REG_HANDLING_TIME, phase == 1 ? 32'hffffffff : pick_value());
         if (phase == 2) begin
            write_reg(mngr_pkg::REG_POLLINATOR_CNT, count_word(62));
            write_reg(mngr_pkg::REG_PLANT_CNT, count_word(2));
         end else if (phase == 5) begin
            write_reg(mngr_pkg::REG_POLLINATOR_CNT, count_word(2));
            write_reg(mngr_pkg::REG_PLANT_CNT, count_word(62));
         end else begin
            write_reg(mngr_pkg::REG_POLLINATOR_CNT, count_word($urandom_range(2, 8)));
            write_reg(mngr_pkg::REG_PLANT_CNT, count_word($urandom_range(2, 8)));
         end
         if (phase == 3) begin
            // fill the edge list past its capacity
            send_item(make_item(mngr_pkg::MODE_CLEAR_EDGES, 0, 0, 0, 0, 0));
            for (int k = 0; k < 262; k++)
               send_item(make_item(mngr_pkg::MODE_APPEND_EDGE, $urandom_range(0, 63),
                                   $urandom, $urandom, $urandom_range(0, 63),
                                   $urandom_range(0, 63)));
            send_item(make_item(mngr_pkg::MODE_EVALUATE, 0, 0, 0, 0, 0));
         end
         items = (phase == 2 || phase == 5) ? 4 : 7;
         for (int k = 0; k < items; k++)
            send_item(random_item((phase == 2 || phase == 5) ? 0 : 10));
         send_item(make_item(mngr_pkg::MODE_EVALUATE, 0, 0, 0, 0, 0));
      end

      drain();
      if (rate_due.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
